// ----- hdl/neighbour_table_engine_assert.svh -----
//------------------------------------------------------------------------------
// neighbour_table_engine_assert
// assertion macros for the neighbour table engine
//------------------------------------------------------------------------------
`ifndef NEIGHBOUR_TABLE_ENGINE_ASSERT_SVH
`define NEIGHBOUR_TABLE_ENGINE_ASSERT_SVH
// implication checked on every edge outside reset
`define NTE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define NTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/nte_pkg.sv -----
//------------------------------------------------------------------------------
// nte_pkg
// shared types and constants of the neighbour table engine
//------------------------------------------------------------------------------
package nte_pkg;
  localparam int unsigned TableDepthDefault = 64;
  localparam logic [31:0] LifetimeReset = 32'd1000;
  localparam logic [19:0] LimitReset = 20'd40000;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusMiss = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic [3:0] OpAdd = 4'd0;
  localparam logic [3:0] OpUpdate = 4'd1;
  localparam logic [3:0] OpDelete = 4'd2;
  localparam logic [3:0] OpPurge = 4'd3;
  localparam logic [3:0] OpBest = 4'd4;
  localparam logic [3:0] OpCount = 4'd5;
  localparam logic [3:0] OpFindVeh = 4'd6;
  localparam logic [3:0] OpFindMsg = 4'd7;
  localparam logic [3:0] OpNearest = 4'd8;
  localparam logic [3:0] OpFindRsu = 4'd9;

  localparam logic [0:0] RegLifetime = 1'd0;
  localparam logic [0:0] RegLimit = 1'd1;

  // entry record as stored in the table memory
  typedef struct packed {
    logic [15:0] vehicle;
    logic [15:0] message;
    logic        rsu;
    logic [31:0] stamp;
    logic [19:0] x;
    logic [19:0] y;
    logic [31:0] density;
    logic [31:0] wdist;
    logic [31:0] dsd;
    logic [31:0] dsr;
    logic [31:0] hop;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // classified command passed from front to back
  typedef struct packed {
    logic [3:0]  op;
    logic        known;
    entry_t      item;
  } cmd_t;

  localparam int unsigned CmdW = $bits(cmd_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_REPORT,
    ST_DONE
  } bst_t;
endpackage

// ----- hdl/nte_ram.sv -----
//------------------------------------------------------------------------------
// nte_ram
// generic single write, single read ram with registered read data
//------------------------------------------------------------------------------
module nte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- hdl/nte_front.sv -----
//------------------------------------------------------------------------------
// nte_front
// accepts input transfers and queues classified commands (two-entry fifo)
//------------------------------------------------------------------------------
module nte_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  nte_pkg::cmd_t  cmd_in,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output nte_pkg::cmd_t  cmd_out
);
  import nte_pkg::*;

  cmd_t        q_r [2];
  cmd_t        q_nxt [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd_out = q_r[0];

  always_comb begin
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      cnt_nxt = cnt_nxt - 2'd1;
    end
    if (push) begin
      q_nxt[cnt_nxt[0]] = cmd_in;
      q_nxt[cnt_nxt[0]].known = (cmd_in.op <= OpFindRsu);
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
  end
endmodule

// ----- hdl/nte_back.sv -----
//------------------------------------------------------------------------------
// nte_back
// executes one command by scanning, compacting or appending the entry ram
//------------------------------------------------------------------------------
module nte_back #(
  parameter int unsigned TABLE_DEPTH = nte_pkg::TableDepthDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  nte_pkg::cmd_t                 cmd,
  input  logic [31:0]                   lifetime,
  input  logic [19:0]                   limit,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [1:0]                    res_status,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] res_count,
  output nte_pkg::entry_t               res_entry,
  output logic                          busy
);
  import nte_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  bst_t        st_r, st_nxt;
  cmd_t        cmd_r;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] rd_i_r, rd_i_nxt;   // next read address
  logic [CW-1:0] k_r, k_nxt;         // compaction write index
  logic        dv_r, dv_nxt;         // read data valid this cycle
  logic [CW-1:0] di_r, di_nxt;       // index of read data
  logic        hit_r, hit_nxt;
  logic [AW-1:0] hit_i_r, hit_i_nxt;
  logic [40:0] best_r, best_nxt;     // best score or squared distance
  logic [40:0] dsq;
  logic [40:0] dx2_r, dy2_r;
  logic        dxv_r, dxrsu_r;
  logic [CW-1:0] dxi_r;
  logic [19:0] ddx, ddy;
  logic [1:0]  stat_r, stat_nxt;
  entry_t      out_r, out_nxt;
  logic        ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] wa, ra;
  entry_t        wd, rd;

  nte_ram #(.WIDTH(EntryW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd)
  );

  logic [32:0] score;
  logic        match;
  logic        keep;
  logic [32:0] purge_lim;
  logic        purge_on;

  assign score = {1'b0, rd.wdist} + {1'b0, rd.density};
  assign purge_on = (cmd_r.item.stamp >= lifetime);
  assign purge_lim = {1'b0, cmd_r.item.stamp - lifetime};
  assign keep = !purge_on || ({1'b0, rd.stamp} >= purge_lim);
  assign ddx = (rd.x > cmd_r.item.x) ? rd.x - cmd_r.item.x : cmd_r.item.x - rd.x;
  assign ddy = (rd.y > cmd_r.item.y) ? rd.y - cmd_r.item.y : cmd_r.item.y - rd.y;
  assign dsq = dx2_r + dy2_r;

  always_comb begin
    case (cmd_r.op)
      OpFindMsg: match = (rd.message == cmd_r.item.message);
      OpFindRsu: match = rd.rsu;
      default:   match = (rd.vehicle == cmd_r.item.vehicle);
    endcase
  end

  // a waiting result holds off the next command
  assign cmd_ready = (st_r == ST_IDLE) && !ov_r;
  assign res_valid = ov_r;
  assign res_status = stat_r;
  assign res_count = n_r;
  assign res_entry = out_r;
  assign busy = (st_r != ST_IDLE) || ov_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          st_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_i_r >= n_r && !dv_r && !dxv_r) begin
          st_nxt = ST_REPORT;
        end
        if (dv_r && match && (cmd_r.op == OpUpdate || cmd_r.op == OpFindVeh
            || cmd_r.op == OpFindMsg || cmd_r.op == OpFindRsu)) begin
          st_nxt = ST_REPORT;
        end
        if (dv_r && match && cmd_r.op == OpDelete) begin
          st_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (rd_i_r >= n_r && !dv_r) begin
          st_nxt = ST_REPORT;
        end
      end
      ST_REPORT: st_nxt = ST_DONE;
      ST_DONE: begin
        if (!ov_r || res_ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_nxt = n_r;
    rd_i_nxt = rd_i_r;
    k_nxt = k_r;
    dv_nxt = 1'b0;
    di_nxt = rd_i_r;
    hit_nxt = hit_r;
    hit_i_nxt = hit_i_r;
    best_nxt = best_r;
    stat_nxt = stat_r;
    out_nxt = out_r;
    ov_nxt = ov_r;
    we = 1'b0;
    wa = k_r[AW-1:0];
    wd = rd;
    ra = rd_i_r[AW-1:0];
    if (ov_r && res_ready) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        rd_i_nxt = '0;
        k_nxt = '0;
        hit_nxt = 1'b0;
        hit_i_nxt = '0;
        best_nxt = {21'd0, limit} * {21'd0, limit};
      end
      ST_SCAN: begin
        if (rd_i_r < n_r && !(cmd_r.op == OpAdd || cmd_r.op == OpCount || !cmd_r.known)) begin
          dv_nxt = 1'b1;
          di_nxt = rd_i_r;
          rd_i_nxt = rd_i_r + 1'b1;
        end else begin
          rd_i_nxt = n_r;
        end
        if (dv_r) begin
          case (cmd_r.op)
            OpPurge: begin
              if (keep) begin
                we = 1'b1;
                wa = k_r[AW-1:0];
                wd = rd;
                k_nxt = k_r + 1'b1;
              end
            end
            OpBest: begin
              if (!hit_r || {8'd0, score} > best_r) begin
                hit_nxt = 1'b1;
                best_nxt = {8'd0, score};
                hit_i_nxt = di_r[AW-1:0];
                out_nxt = rd;
              end
            end
            OpNearest: ;
            default: begin
              if (match && !hit_r) begin
                hit_nxt = 1'b1;
                hit_i_nxt = di_r[AW-1:0];
                out_nxt = rd;
                k_nxt = di_r;
                if (cmd_r.op == OpUpdate) begin
                  we = 1'b1;
                  wa = di_r[AW-1:0];
                  wd = cmd_r.item;
                  out_nxt = cmd_r.item;
                end
                if (cmd_r.op == OpDelete) begin
                  rd_i_nxt = di_r + 1'b1;
                  dv_nxt = 1'b0;
                end
              end
            end
          endcase
        end
        if (dxv_r && !dxrsu_r && dsq < best_r) begin
          hit_nxt = 1'b1;
          best_nxt = dsq;
          hit_i_nxt = dxi_r[AW-1:0];
        end
      end
      ST_SHIFT: begin
        if (rd_i_r < n_r) begin
          dv_nxt = 1'b1;
          rd_i_nxt = rd_i_r + 1'b1;
        end
        if (dv_r) begin
          we = 1'b1;
          wa = k_r[AW-1:0];
          wd = rd;
          k_nxt = k_r + 1'b1;
        end
      end
      ST_REPORT: begin
        // nearest fetches the winning entry now
        ra = hit_i_r;
        stat_nxt = hit_r ? StatusOk : StatusMiss;
        case (cmd_r.op)
          OpAdd: begin
            if (n_r < CW'(TABLE_DEPTH)) begin
              we = 1'b1;
              wa = n_r[AW-1:0];
              wd = cmd_r.item;
              n_nxt = n_r + 1'b1;
              stat_nxt = StatusOk;
            end else begin
              stat_nxt = StatusFull;
            end
          end
          OpPurge: begin
            n_nxt = k_r;
            stat_nxt = StatusOk;
          end
          OpDelete: begin
            if (hit_r) begin
              n_nxt = n_r - 1'b1;
            end
          end
          OpCount: stat_nxt = StatusOk;
          default: ;
        endcase
        if (!cmd_r.known) begin
          stat_nxt = StatusMiss;
        end
      end
      ST_DONE: begin
        ra = hit_i_r;
        if (!ov_r || res_ready) begin
          ov_nxt = 1'b1;
          if (cmd_r.op == OpNearest && hit_r) begin
            out_nxt = rd;
          end
          if (!hit_r || cmd_r.op == OpAdd || cmd_r.op == OpPurge
              || cmd_r.op == OpCount) begin
            out_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      n_r <= '0;
      ov_r <= 1'b0;
      dv_r <= 1'b0;
      dxv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      n_r <= n_nxt;
      ov_r <= ov_nxt;
      dv_r <= dv_nxt;
      dxv_r <= dv_r && (st_r == ST_SCAN) && (cmd_r.op == OpNearest);
    end
    if (cmd_valid && cmd_ready) begin
      cmd_r <= cmd;
    end
    rd_i_r <= rd_i_nxt;
    k_r <= k_nxt;
    di_r <= di_nxt;
    hit_r <= hit_nxt;
    hit_i_r <= hit_i_nxt;
    best_r <= best_nxt;
    stat_r <= stat_nxt;
    out_r <= out_nxt;
    dx2_r <= {1'b0, 40'(ddx) * 40'(ddx)};
    dy2_r <= {1'b0, 40'(ddy) * 40'(ddy)};
    dxrsu_r <= rd.rsu;
    dxi_r <= di_r;
  end
endmodule

// ----- hdl/neighbour_table_engine.sv -----
// neighbour_table_engine: bounded neighbour table kept in arrival order
// scans walk the stored entries in order through the single entry ram read port
// only one operation runs at a time
// a two-deep command queue takes transfers while an operation runs or a result waits
// reset (synchronous, rst_n low) empties the table, registers take defaults
//------------------------------------------------------------------------------
// neighbour_table_engine
// top level: apb registers, command queue front and table back end
//------------------------------------------------------------------------------
module neighbour_table_engine #(
  parameter int unsigned TABLE_DEPTH = nte_pkg::TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_operation,
  input  logic [15:0] in_vehicle_id,
  input  logic [15:0] in_message_id,
  input  logic        in_is_rsu,
  input  logic [31:0] in_time_ms,
  input  logic [19:0] in_pos_x,
  input  logic [19:0] in_pos_y,
  input  logic [31:0] in_weighted_distance,
  input  logic [31:0] in_density,
  input  logic [31:0] in_dist_to_destination,
  input  logic [31:0] in_dist_to_source,
  input  logic [31:0] in_hop_score,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_found_id,
  output logic [6:0]  out_entry_count,
  output logic [19:0] out_found_x,
  output logic [19:0] out_found_y,
  output logic [31:0] out_found_density,
  output logic [31:0] out_found_weighted_distance,
  output logic [31:0] out_found_dist_destination,
  output logic [31:0] out_found_dist_source,
  output logic [31:0] out_found_hop_score,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import nte_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // configuration registers
  logic [31:0] lifetime_r;
  logic [19:0] limit_r;
  logic        cfg_wr;
  logic [0:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[2:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= LifetimeReset;
      limit_r <= LimitReset;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'd0) begin
      case (cfg_idx)
        RegLifetime: lifetime_r <= cfg_pwdata;
        RegLimit:    limit_r <= cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegLifetime: cfg_prdata = lifetime_r;
      RegLimit:    cfg_prdata = {12'd0, limit_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // incoming transfer packed as a command
  cmd_t cmd_in, cmd_q;
  logic cmd_valid, cmd_ready;

  always_comb begin
    cmd_in.op = in_operation;
    cmd_in.known = 1'b0;
    cmd_in.item.vehicle = in_vehicle_id;
    cmd_in.item.message = in_message_id;
    cmd_in.item.rsu = in_is_rsu;
    cmd_in.item.stamp = in_time_ms;
    cmd_in.item.x = in_pos_x;
    cmd_in.item.y = in_pos_y;
    cmd_in.item.density = in_density;
    cmd_in.item.wdist = in_weighted_distance;
    cmd_in.item.dsd = in_dist_to_destination;
    cmd_in.item.dsr = in_dist_to_source;
    cmd_in.item.hop = in_hop_score;
  end

  nte_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .cmd_in(cmd_in), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_out(cmd_q)
  );

  entry_t        res_entry;
  logic [CW-1:0] res_count;
  logic          busy;

  nte_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd_q), .lifetime(lifetime_r), .limit(limit_r),
    .res_valid(out_valid), .res_ready(out_ready), .res_status(out_status),
    .res_count(res_count), .res_entry(res_entry), .busy(busy)
  );

  // result fields
  assign out_entry_count = 7'(res_count);
  assign out_found_id = res_entry.vehicle;
  assign out_found_x = res_entry.x;
  assign out_found_y = res_entry.y;
  assign out_found_density = res_entry.density;
  assign out_found_weighted_distance = res_entry.wdist;
  assign out_found_dist_destination = res_entry.dsd;
  assign out_found_dist_source = res_entry.dsr;
  assign out_found_hop_score = res_entry.hop;

`include "neighbour_table_engine_assert.svh"

  // the count never exceeds the table depth
  `NTE_ASSERT_IMP(a_count_range, 1'b1, res_count <= CW'(TABLE_DEPTH))
  // a full status is only given when the table holds every entry
  `NTE_ASSERT_IMP(a_full_only_when_full, out_valid && out_status == StatusFull,
    res_count == CW'(TABLE_DEPTH))
  // an undelivered result keeps the back end busy
  `NTE_ASSERT_NEXT(a_busy_hold, out_valid && !out_ready, busy && out_valid)
endmodule
